FILE: design/vertex_transform_4x4_assert.svh
// Assertion macros for the vertex transform block.
// Included by modules that check their own pipeline control; expects clk_i and rst_ni.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// same-cycle implication
`define VT4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vt4 check failed");

// next-cycle implication
`define VT4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vt4 check failed");

`endif

FILE: design/vt4_pkg.sv
// Shared types and constants for the vertex transform block.
// No dependencies; used by every module of the block.
`default_nettype none

package vt4_pkg;

  localparam int FIELD_W   = 32;  // width of every vector and result field
  localparam int CFG_W     = 64;  // width of one matrix register
  localparam int CFG_IDX_W = 4;   // width of the register index port
  localparam int CFG_SEL_W = 3;   // bits that select one of the matrix registers
  localparam int NUM_CFG   = 8;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;

  typedef enum logic [1:0] {
    OP_AFFINE    = 2'd0,
    OP_DIRECTION = 2'd1,
    OP_HOMOG     = 2'd2,
    OP_PLANAR    = 2'd3
  } vt4_op_e;

  typedef struct packed {
    vt4_op_e              operation;
    logic [FIELD_W-1:0]   in_x;
    logic [FIELD_W-1:0]   in_y;
    logic [FIELD_W-1:0]   in_z;
    logic [FIELD_W-1:0]   in_w;
  } vt4_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   out_x;
    logic [FIELD_W-1:0]   out_y;
    logic [FIELD_W-1:0]   out_z;
    logic [FIELD_W-1:0]   out_w;
    logic                 saturated;
  } vt4_out_t;

  // stage load enables shared by all row lanes
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } vt4_pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: design/vt4_cfg.sv
// Matrix register file: eight 64-bit registers, identity after reset.
// Unpacks the sixteen signed coefficients; depends on vt4_pkg.
`default_nettype none

module vt4_cfg #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [vt4_pkg::CFG_W-1:0]             cfg_data_i,
  output logic signed [DATA_WIDTH-1:0]          coef_o [vt4_pkg::NUM_ROWS][vt4_pkg::NUM_COLS]
);

  localparam int NREG = vt4_pkg::NUM_CFG;
  localparam int HW   = vt4_pkg::CFG_W / 2;
  localparam logic [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
  localparam logic [vt4_pkg::CFG_W-1:0] RST_VAL [NREG] = '{
    {{HW{1'b0}}, ONE_H}, '0,
    {ONE_H, {HW{1'b0}}}, '0,
    '0, {{HW{1'b0}}, ONE_H},
    '0, {ONE_H, {HW{1'b0}}}
  };

  logic [vt4_pkg::CFG_W-1:0] regs_q [NREG];
  logic                      wr_en;

  assign cfg_ready_o = 1'b1;
  // indexes past the last register are dropped
  assign wr_en = cfg_valid_i && (cfg_index_i < vt4_pkg::CFG_IDX_W'(NREG));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) begin
        regs_q[i] <= RST_VAL[i];
      end
    end else if (wr_en) begin
      regs_q[cfg_index_i[vt4_pkg::CFG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // row r, column c lives in register 2r + c/2, half c%2
  for (genvar r = 0; r < vt4_pkg::NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < vt4_pkg::NUM_COLS; c++) begin : g_col
      assign coef_o[r][c] = regs_q[2*r + c/2][HW*(c%2) +: DATA_WIDTH];
    end
  end

endmodule

`default_nettype wire

FILE: design/vt4_row_dot.sv
// One matrix row lane: four products, pairwise adds, final add with fraction drop.
// Three register stages, then a saturating clip; depends on vt4_pkg.
`default_nettype none

module vt4_row_dot #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int VEC_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  vt4_pkg::vt4_pipe_ctrl_t       ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]  coef_i [vt4_pkg::NUM_COLS],
  input  logic signed [VEC_WIDTH-1:0]   vec_i [vt4_pkg::NUM_COLS],
  output logic signed [DATA_WIDTH-1:0]  res_o,
  output logic                          ovf_o
);

  localparam int PW = DATA_WIDTH + VEC_WIDTH;   // full product
  localparam int SW = PW + 2;                   // sum of four products
  localparam int QW = SW - FRAC_BITS;           // after dropping the fraction
  localparam int NC = vt4_pkg::NUM_COLS;

  logic signed [PW-1:0]   prod_q [NC];
  logic signed [PW:0]     pair_q [NC/2];
  logic signed [QW-1:0]   sum_q;
  logic signed [SW-1:0]   total;
  logic [QW-DATA_WIDTH:0] upper;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      for (int c = 0; c < NC; c++) begin
        prod_q[c] <= PW'(coef_i[c]) * PW'(vec_i[c]);
      end
    end
    if (ctrl_i.en2) begin
      for (int k = 0; k < NC/2; k++) begin
        pair_q[k] <= (PW+1)'(prod_q[2*k]) + (PW+1)'(prod_q[2*k+1]);
      end
    end
    if (ctrl_i.en3) begin
      sum_q <= total[SW-1:FRAC_BITS];  // floor division by 2^FRAC_BITS
    end
  end

  assign total = SW'(pair_q[0]) + SW'(pair_q[1]);

  // out of range unless all bits from the DATA_WIDTH sign bit up agree
  assign upper = sum_q[QW-1:DATA_WIDTH-1];
  assign ovf_o = !((&upper) || (~|upper));

  always_comb begin
    if (!ovf_o) begin
      res_o = sum_q[DATA_WIDTH-1:0];
    end else if (sum_q[QW-1]) begin
      res_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: design/vertex_transform_4x4.sv
// Top level of the 4x4 matrix-vector transform; instantiates vt4_cfg and four vt4_row_dot.
// Depends on vt4_pkg and vertex_transform_4x4_assert.svh.
//
// Applies the configured 4x4 Q16.16 matrix to one vector per item. A new item is
// taken every cycle while the input is not stalled; its result is registered in
// turn by multiply, pair add, final add with the fraction dropped, then clip and
// mode select into the output register. Sixteen DATA_WIDTH-by-VW multipliers
// (four per row lane) work in parallel. A stalled output only holds the stages
// behind it that are full, so empty stages keep filling while a result waits.
// The matrix resets to identity; write it only while no item is in flight.
`default_nettype none

module vertex_transform_4x4 #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vt4_pkg::vt4_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vt4_pkg::vt4_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vt4_pkg::CFG_W-1:0]         cfg_data_i
);

  `include "vertex_transform_4x4_assert.svh"

  localparam int DW = DATA_WIDTH;
  localparam int FW = vt4_pkg::FIELD_W;
  localparam int VW = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
  localparam int NR = vt4_pkg::NUM_ROWS;
  localparam int NC = vt4_pkg::NUM_COLS;
  localparam bit ONE_FITS = FRAC_BITS < DATA_WIDTH - 1;
  localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] ONE_OUT =
    ONE_FITS ? (DW'(1) << FRAC_BITS) : {1'b0, {(DW-1){1'b1}}};

  logic signed [DW-1:0] coef [NR][NC];
  logic signed [VW-1:0] vec [NC];
  logic signed [DW-1:0] res [NR];
  logic [NR-1:0]        ovf;

  vt4_pkg::vt4_pipe_ctrl_t ctrl;
  logic                    en4;
  logic                    v1_q, v2_q, v3_q, out_valid_q;
  vt4_pkg::vt4_op_e        op1_q, op2_q, op3_q;
  vt4_pkg::vt4_out_t       out_d, out_q;
  logic signed [DW-1:0]    z_res, w_res;
  logic                    sat;

  vt4_cfg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // a stage loads when it is empty or the one ahead moves on
  assign en4       = !out_valid_q || !out_stall_i;
  assign ctrl.en3  = !v3_q || en4;
  assign ctrl.en2  = !v2_q || ctrl.en3;
  assign ctrl.en1  = !v1_q || ctrl.en2;
  assign in_stall_o = !ctrl.en1;

  // operand vector: missing components per mode
  always_comb begin
    vec[0] = VW'($signed(in_data_i.in_x[DW-1:0]));
    vec[1] = VW'($signed(in_data_i.in_y[DW-1:0]));
    vec[2] = VW'($signed(in_data_i.in_z[DW-1:0]));
    vec[3] = VW'($signed(in_data_i.in_w[DW-1:0]));
    unique case (in_data_i.operation)
      vt4_pkg::OP_AFFINE: begin
        vec[3] = ONE_V;
      end
      vt4_pkg::OP_DIRECTION: begin
        vec[3] = '0;
      end
      vt4_pkg::OP_HOMOG: begin
      end
      vt4_pkg::OP_PLANAR: begin
        vec[2] = '0;
        vec[3] = ONE_V;
      end
    endcase
  end

  for (genvar r = 0; r < NR; r++) begin : g_lane
    vt4_row_dot #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .VEC_WIDTH  (VW)
    ) u_row (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .coef_i (coef[r]),
      .vec_i  (vec),
      .res_o  (res[r]),
      .ovf_o  (ovf[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      op1_q       <= vt4_pkg::OP_AFFINE;
      op2_q       <= vt4_pkg::OP_AFFINE;
      op3_q       <= vt4_pkg::OP_AFFINE;
    end else begin
      if (ctrl.en1) v1_q <= in_valid_i;
      if (ctrl.en2) v2_q <= v1_q;
      if (ctrl.en3) v3_q <= v2_q;
      if (en4)      out_valid_q <= v3_q;
      if (ctrl.en1) op1_q <= in_data_i.operation;
      if (ctrl.en2) op2_q <= op1_q;
      if (ctrl.en3) op3_q <= op2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4)      out_q <= out_d;
  end

  // z is zero in planar mode, w is one outside homogeneous mode
  always_comb begin
    z_res = res[2];
    w_res = ONE_OUT;
    sat   = ovf[0] || ovf[1];
    unique case (op3_q)
      vt4_pkg::OP_AFFINE, vt4_pkg::OP_DIRECTION: begin
        sat = sat || ovf[2] || !ONE_FITS;
      end
      vt4_pkg::OP_HOMOG: begin
        w_res = res[3];
        sat   = sat || ovf[2] || ovf[3];
      end
      vt4_pkg::OP_PLANAR: begin
        z_res = '0;
        sat   = sat || !ONE_FITS;
      end
    endcase
    out_d.out_x     = FW'(res[0]);
    out_d.out_y     = FW'(res[1]);
    out_d.out_z     = FW'(z_res);
    out_d.out_w     = FW'(w_res);
    out_d.saturated = sat;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // input may only stall when every stage holds an item
  `VT4_ASSERT_NOW(a_stall_only_full, in_stall_o, v1_q && v2_q && v3_q && out_valid_q)
  // an accepted item occupies the first stage on the next cycle
  `VT4_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, v1_q)
  // a full last stage that moves on becomes a visible result
  `VT4_ASSERT_NEXT(a_stage3_drains, v3_q && en4, out_valid_q)
  // a result that was not taken is still offered
  `VT4_ASSERT_NEXT(a_result_held, out_valid_q && out_stall_i, out_valid_q && $stable(out_q))

endmodule

`default_nettype wire
